// ===== rtl/ppdd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdd_pkg
// Shared types, widths, register indexes and saturation helpers for the
// positional PID digipot drive.
// ----------------------------------------------------------------------------
package ppdd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VBASE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_R1         = 3'd7;

  // Serial multiplier: A operand magnitude, B operand shifted out bit by bit
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 48;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Serial divider: remainder width and quotient width
  localparam int DIV_W  = 80;
  localparam int DIV_QW = 38;
  localparam int CNT_W  = 6;

  localparam int MS_PER_S      = 1000;
  localparam int POT_FULL_KOHM = 50;
  // Quotient of the integration step fits below 2^38
  localparam int INC_SHIFT     = DIV_QW - 1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MEAS = 10'b00_0000_0010,
    S_INCM = 10'b00_0000_0100,
    S_INCD = 10'b00_0000_1000,
    S_TP   = 10'b00_0001_0000,
    S_TI   = 10'b00_0010_0000,
    S_TD   = 10'b00_0100_0000,
    S_MAPM = 10'b00_1000_0000,
    S_MAPD = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  localparam logic signed [67:0] S32_MAX = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [67:0] S32_MIN = -S32_MAX - 68'sd1;
  localparam logic signed [49:0] S48_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] S48_MIN = -S48_MAX - 50'sd1;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > S48_MAX) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < S48_MIN) r = 48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic [48:0] abs49(input logic signed [48:0] v);
    logic [48:0] r;
    r = v[48] ? 49'(-v) : 49'(v);
    return r;
  endfunction

endpackage

// ===== rtl/ppdd_mul.sv =====
// ----------------------------------------------------------------------------
// ppdd_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ppdd_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ppdd_pkg::MUL_AW-1:0] a,
  input  logic [ppdd_pkg::MUL_BW-1:0] b,
  output ppdd_pkg::unit_stat_t       stat,
  output logic [ppdd_pkg::MUL_PW-1:0] prod
);
  import ppdd_pkg::*;

  logic [MUL_PW-1:0] acc;
  logic [MUL_AW-1:0] a_q;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [MUL_AW:0]   hi_sum;

  // Add the multiplicand into the upper half when the low bit is set
  assign hi_sum = {1'b0, acc[MUL_PW-1:MUL_BW]} + (acc[0] ? {1'b0, a_q} : '0);

  // Load, then shift right once per multiplier bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= {{MUL_AW{1'b0}}, b};
        a_q  <= a;
        cnt  <= CNT_W'(MUL_BW);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= {hi_sum, acc[MUL_BW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/ppdd_div.sv =====
// ----------------------------------------------------------------------------
// ppdd_div
// Restoring divider, one quotient bit per cycle. The caller gives the divisor
// already aligned to the top quotient bit and the number of steps.
// ----------------------------------------------------------------------------
module ppdd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ppdd_pkg::DIV_W-1:0]  num,
  input  logic [ppdd_pkg::DIV_W-1:0]  dsh,
  input  logic [ppdd_pkg::CNT_W-1:0]  steps,
  output ppdd_pkg::unit_stat_t        stat,
  output logic [ppdd_pkg::DIV_QW-1:0] quo
);
  import ppdd_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_QW-1:0] q;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic              ge;

  assign ge = (rem >= dvs);

  // Compare, subtract, shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dvs  <= dsh;
        q    <= '0;
        cnt  <= steps;
        busy <= 1'b1;
      end else if (busy) begin
        if (ge) rem <= rem - dvs;
        q   <= {q[DIV_QW-2:0], ge};
        dvs <= {1'b0, dvs[DIV_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo       = q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/positional_pid_digipot_drive_unit.sv =====
// ----------------------------------------------------------------------------
// positional_pid_digipot_drive_unit
// Positional PID on one ADC sample per item, mapped to a digipot wiper code.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata[11:0] adc_sample
// m_*       out  m_tvalid/m_tready    m_tdata pot_code, control_output;
//                                     m_tuser clamped_high, clamped_low
// cfg_*     in   cfg_wr_en            cfg_index, cfg_data
//
// A result loads once its item has passed six 48-step serial multiplies, a
// 38-step divide for the integration step and a 9-step divide for the wiper
// code, all on one shared multiplier and one restoring divider; with a zero
// base voltage the last multiply and the wiper-code divide are skipped.
// One item is in work at a time; the finished result waits in the output
// register while the next item is accepted, and a result not yet taken holds
// the next one back. Synchronous reset restores the register defaults and
// clears the integral and previous error.
// ----------------------------------------------------------------------------
module positional_pid_digipot_drive_unit #(
  parameter int ADC_BITS     = 12,
  parameter int POT_MAX_CODE = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ppdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [11:0] adc_sample
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // [7:0] pot_code, [39:8] control_output
  output logic [1:0]                     m_tuser    // [0] clamped_high, [1] clamped_low
);
  import ppdd_pkg::*;

  localparam int QQ = $clog2(POT_MAX_CODE + 1);
  localparam logic [11:0] ADC_MASK = 12'((17'd1 << ADC_BITS) - 17'd1);
  localparam logic [CNT_W-1:0] MAP_STEPS = CNT_W'(QQ + 1);
  localparam logic [CNT_W-1:0] INC_STEPS = CNT_W'(DIV_QW);
  localparam logic [DIV_QW-1:0] QMAX = DIV_QW'(POT_MAX_CODE);
  localparam logic [7:0] CODE_MAX = 8'(POT_MAX_CODE);

  // Configuration registers
  logic signed [31:0] setpoint, kp, ki, kd;
  logic [15:0]        period;
  logic [31:0]        adc_scale;
  logic [30:0]        vbase, r1;

  // Control and state
  state_t             state;
  logic               launched;
  logic [11:0]        adc_q;
  logic signed [31:0] err, prev_err, u;
  logic signed [47:0] integ;
  logic signed [67:0] sum;
  logic               map_neg;
  logic [7:0]         code;
  logic               hi_flag, lo_flag;

  // Unit connections
  logic                 mul_start, div_start;
  logic [MUL_AW-1:0]    mul_a;
  logic [MUL_BW-1:0]    mul_b;
  logic [MUL_PW-1:0]    mul_p;
  unit_stat_t           mul_stat, div_stat;
  logic [DIV_W-1:0]     div_num, div_dsh;
  logic [CNT_W-1:0]     div_steps;
  logic [DIV_QW-1:0]    div_q;

  // Derived values
  logic [48:0]        meas49;
  logic signed [41:0] err_wide;
  logic [32:0]        err_abs, kp_abs, ki_abs, kd_abs, diff_abs, map_mag;
  logic [47:0]        integ_abs;
  logic signed [32:0] diff;
  logic signed [49:0] inc, integ_sum;
  logic signed [67:0] term;
  logic               term_neg;
  logic signed [33:0] s34;
  logic [47:0]        r1p;
  logic [36:0]        vd;
  logic               big;

  ppdd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_stat),
    .prod  (mul_p)
  );

  ppdd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dsh   (div_dsh),
    .steps (div_steps),
    .stat  (div_stat),
    .quo   (div_q)
  );

  // Form error, magnitudes and terms
  always_comb begin
    meas49    = {1'b0, mul_p[47:0]} + 49'd128;
    err_wide  = 42'(setpoint) - $signed({1'b0, meas49[48:8]});
    err_abs   = 33'(abs49(49'(err)));
    kp_abs    = 33'(abs49(49'(kp)));
    ki_abs    = 33'(abs49(49'(ki)));
    kd_abs    = 33'(abs49(49'(kd)));
    integ_abs = 48'(abs49(49'(integ)));
    diff      = 33'(err) - 33'(prev_err);
    diff_abs  = 33'(abs49(49'(diff)));
    inc       = err[31] ? -$signed(50'(div_q)) : $signed(50'(div_q));
    integ_sum = 50'(integ) + inc;
    s34       = 34'(u) - $signed({3'b0, vbase});
    map_mag   = 33'(abs49(49'(s34)));
    r1p       = 48'(r1) * 48'(POT_MAX_CODE);
    vd        = 37'(vbase) * 37'(POT_FULL_KOHM);
    big       = (div_q > QMAX);
    case (state)
      S_TP:    term_neg = kp[31] ^ err[31];
      S_TI:    term_neg = ki[31] ^ integ[47];
      default: term_neg = kd[31] ^ diff[32];
    endcase
    term = term_neg ? -$signed({3'b0, mul_p[MUL_PW-1:16]})
                    : $signed({3'b0, mul_p[MUL_PW-1:16]});
  end

  // Select unit operands per state
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_start = 1'b0;
    div_num   = mul_p[DIV_W-1:0];
    div_dsh   = DIV_W'(MS_PER_S) << INC_SHIFT;
    div_steps = INC_STEPS;
    div_start = 1'b0;
    case (state)
      S_MEAS: begin
        mul_a     = {1'b0, adc_scale};
        mul_b     = 48'(adc_q & ADC_MASK);
        mul_start = !launched;
      end
      S_INCM: begin
        mul_a     = err_abs;
        mul_b     = 48'(period);
        mul_start = !launched;
      end
      S_INCD: begin
        div_start = !launched;
      end
      S_TP: begin
        mul_a     = kp_abs;
        mul_b     = 48'(err_abs);
        mul_start = !launched;
      end
      S_TI: begin
        mul_a     = ki_abs;
        mul_b     = integ_abs;
        mul_start = !launched;
      end
      S_TD: begin
        mul_a     = kd_abs;
        mul_b     = 48'(diff_abs);
        mul_start = !launched;
      end
      S_MAPM: begin
        mul_a     = map_mag;
        mul_b     = r1p;
        mul_start = !launched && (vbase != '0);
      end
      S_MAPD: begin
        div_dsh   = DIV_W'(vd) << (16 + QQ);
        div_steps = MAP_STEPS;
        div_start = !launched;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint  <= 32'sd655360;
      kp        <= 32'sd65536;
      ki        <= 32'sd65536;
      kd        <= 32'sd65536;
      period    <= 16'd10;
      adc_scale <= 32'd13517;
      vbase     <= 31'd655360;
      r1        <= 31'd655360;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETPOINT:  setpoint  <= cfg_data;
        REG_KP:        kp        <= cfg_data;
        REG_KI:        ki        <= cfg_data;
        REG_KD:        kd        <= cfg_data;
        REG_PERIOD:    period    <= cfg_data[15:0];
        REG_ADC_SCALE: adc_scale <= cfg_data;
        REG_VBASE:     vbase     <= cfg_data[30:0];
        REG_R1:        r1        <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequence the item through the shared units
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      launched <= 1'b0;
      m_tvalid <= 1'b0;
      prev_err <= '0;
      integ    <= '0;
    end else begin
      // Raise valid when a result loads, drop it once taken
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mul_start || div_start) launched <= 1'b1;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            adc_q <= s_tdata[11:0];
            sum   <= '0;
            state <= S_MEAS;
          end
        end
        S_MEAS: begin
          if (launched && mul_stat.done) begin
            err      <= sat32(68'(err_wide));
            launched <= 1'b0;
            state    <= S_INCM;
          end
        end
        S_INCM: begin
          if (launched && mul_stat.done) begin
            launched <= 1'b0;
            state    <= S_INCD;
          end
        end
        S_INCD: begin
          if (launched && div_stat.done) begin
            integ    <= sat48(integ_sum);
            launched <= 1'b0;
            state    <= S_TP;
          end
        end
        S_TP, S_TI: begin
          if (launched && mul_stat.done) begin
            sum      <= sum + term;
            launched <= 1'b0;
            state    <= (state == S_TP) ? S_TI : S_TD;
          end
        end
        S_TD: begin
          if (launched && mul_stat.done) begin
            u        <= sat32(sum + term);
            prev_err <= err;
            launched <= 1'b0;
            state    <= S_MAPM;
          end
        end
        S_MAPM: begin
          map_neg <= s34[33];
          if (vbase == '0) begin
            // Zero divisor: saturate by the sign of u * R1
            hi_flag <= (r1 != '0) && !u[31] && (u != '0);
            lo_flag <= (r1 != '0) && u[31];
            code    <= ((r1 != '0) && !u[31] && (u != '0)) ? CODE_MAX : 8'd0;
            state   <= S_OUT;
          end else if (launched && mul_stat.done) begin
            launched <= 1'b0;
            state    <= S_MAPD;
          end
        end
        S_MAPD: begin
          if (launched && div_stat.done) begin
            launched <= 1'b0;
            if (!map_neg) begin
              hi_flag <= big;
              lo_flag <= 1'b0;
              code    <= big ? CODE_MAX : div_q[7:0];
            end else begin
              hi_flag <= 1'b0;
              lo_flag <= big || (div_q != '0);
              code    <= 8'd0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {u, code};
            m_tuser  <= {lo_flag, hi_flag};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ppdd_checker.sv =====
// ----------------------------------------------------------------------------
// ppdd_checker
// Port-level checks on the PID digipot drive, bound to the top level.
// ----------------------------------------------------------------------------
module ppdd_checker #(
  parameter int POT_MAX_CODE = 255
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Flags never both set
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("both clamp flags set");

  // High clamp gives the full-scale code
  a_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'(POT_MAX_CODE))
    else $error("high clamp without full-scale code");

  // Low clamp gives code zero
  a_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[7:0] == 8'd0)
    else $error("low clamp with nonzero code");

  // One item in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

endmodule

bind positional_pid_digipot_drive_unit ppdd_checker #(.POT_MAX_CODE(POT_MAX_CODE)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional PID digipot drive: a bit-exact
// predictor computes every result from the accepted ADC samples and the
// current register settings, and a monitor compares each accepted result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppdd_pkg::*;

  localparam int POT_MAX = 255;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [7:0]  pot_code;
    logic [31:0] control_output;
    logic        clamped_high;
    logic        clamped_low;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predictor copy of registers and loop state
  logic [31:0] reg_shadow [8];
  longint      prev_err;
  longint      integ;

  drive_t      expected_q [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  longint      cycles = 0;

  positional_pid_digipot_drive_unit i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("positional_pid_digipot_drive_unit test failed");
      $finish;
    end
  end

  function automatic longint sat_to(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  // sign * floor(|a|*|b| / 2^16)
  function automatic longint q16_product(longint a, longint b);
    logic [63:0] ma, mb, mag;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mag = ((ma * (mb >> 24)) << 8) + ((ma * (mb & 64'hFFFFFF)) >> 16);
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void reset_shadow();
    reg_shadow[REG_SETPOINT]  = 655360;
    reg_shadow[REG_KP]        = 65536;
    reg_shadow[REG_KI]        = 65536;
    reg_shadow[REG_KD]        = 65536;
    reg_shadow[REG_PERIOD]    = 10;
    reg_shadow[REG_ADC_SCALE] = 13517;
    reg_shadow[REG_VBASE]     = 655360;
    reg_shadow[REG_R1]        = 655360;
    prev_err = 0;
    integ = 0;
  endfunction

  // Advance the controller one tick and return the drive result
  function automatic drive_t predict_drive(logic [15:0] sample);
    drive_t      res;
    logic [63:0] meas, vbase, r1, mag, num, den, quo, rem, m;
    longint      err, u, s;
    logic        big, neg;
    vbase = 64'(reg_shadow[REG_VBASE] & 32'h7FFF_FFFF);
    r1    = 64'(reg_shadow[REG_R1] & 32'h7FFF_FFFF);
    meas  = ((64'(sample[11:0]) * 64'(reg_shadow[REG_ADC_SCALE])) + 128) >> 8;
    err   = sat_to(longint'($signed(reg_shadow[REG_SETPOINT])) - longint'(meas), 32);
    integ = sat_to(integ + (err * longint'(reg_shadow[REG_PERIOD][15:0])) / 1000, 48);
    u = q16_product(longint'($signed(reg_shadow[REG_KP])), err)
      + q16_product(longint'($signed(reg_shadow[REG_KI])), integ)
      + q16_product(longint'($signed(reg_shadow[REG_KD])), err - prev_err);
    u = sat_to(u, 32);
    prev_err = err;
    res = '0;
    res.control_output = u[31:0];
    if (vbase == 0) begin
      if (u > 0 && r1 != 0) begin
        res.pot_code = 8'(POT_MAX);
        res.clamped_high = 1'b1;
      end else if (u < 0 && r1 != 0) begin
        res.clamped_low = 1'b1;
      end
    end else begin
      s   = u - longint'(vbase);
      neg = s < 0;
      mag = neg ? -s : s;
      num = mag * r1;
      den = vbase * 50 * 65536;
      quo = num / den;
      rem = num % den;
      big = quo > POT_MAX;
      m = 0;
      if (!big) begin
        m = quo * POT_MAX + (rem * POT_MAX) / den;
        if (m > POT_MAX) big = 1'b1;
      end
      if (!neg) begin
        res.pot_code = big ? 8'(POT_MAX) : m[7:0];
        res.clamped_high = big;
      end else if (big || m >= 1) begin
        res.clamped_low = 1'b1;
      end
    end
    return res;
  endfunction

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    drive_t got, exp_res;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tdata[39:8], m_tuser[0], m_tuser[1]};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_res = expected_q.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_res, got);
          end
        end
      end
    end
  end

  // Send one ADC sample and predict its result at acceptance
  task automatic send_sample(logic [15:0] sample);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(predict_drive(sample));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PERIOD:           reg_shadow[idx] = {16'd0, val[15:0]};
      REG_VBASE, REG_R1:    reg_shadow[idx] = {1'b0, val[30:0]};
      default:              reg_shadow[idx] = val;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample(16'd0);
    send_sample(16'd4095);
    send_sample(16'hFFFF);
    send_sample(16'hF000);
    send_sample(16'd2048);
    drain();
  endtask

  task automatic test_directed_extremes();
    // Zero base voltage: saturate high, low and zero-flagless
    write_reg(REG_VBASE, 32'd0);
    write_reg(REG_SETPOINT, 32'h7FFF_FFFF);
    send_sample(16'd0);
    drain();
    write_reg(REG_SETPOINT, 32'h8000_0000);
    send_sample(16'd4095);
    drain();
    write_reg(REG_R1, 32'd0);
    send_sample(16'd100);
    drain();
    // Max gains and scales push the error and the control output into saturation
    write_reg(REG_VBASE, 32'h7FFF_FFFF);
    write_reg(REG_R1, 32'h7FFF_FFFF);
    write_reg(REG_KP, 32'h7FFF_FFFF);
    write_reg(REG_KI, 32'h8000_0000);
    write_reg(REG_KD, 32'h7FFF_FFFF);
    write_reg(REG_PERIOD, 32'h0000_FFFF);
    write_reg(REG_ADC_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_SETPOINT, 32'h8000_0000);
    repeat (4) send_sample(16'd4095);
    drain();
    write_reg(REG_SETPOINT, 32'h7FFF_FFFF);
    repeat (4) send_sample(16'd0);
    drain();
    // Zero period holds the integral; small negative code truncates to zero
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_KP, 32'h0001_0000);
    write_reg(REG_KI, 32'd0);
    write_reg(REG_KD, 32'd0);
    write_reg(REG_ADC_SCALE, 32'd0);
    write_reg(REG_VBASE, 32'h0001_0000);
    write_reg(REG_R1, 32'h0000_0100);
    write_reg(REG_SETPOINT, 32'h0000_FF00);
    send_sample(16'd1);
    drain();
    write_reg(REG_SETPOINT, 32'h0001_0100);
    send_sample(16'd2);
    drain();
  endtask

  task automatic randomize_regs(bit extreme);
    logic [31:0] v;
    for (int i = 0; i < 8; i++) begin
      v = extreme ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h8000_0000) : $urandom();
      case (i)
        REG_SETPOINT: if (!extreme) v = $signed($urandom_range(1_500_000)) - 32'sd300_000;
        REG_KP, REG_KI, REG_KD:
          if (!extreme && $urandom_range(3) != 0) v = $urandom_range(0, 300_000) - 100_000;
        REG_PERIOD: if (!extreme && $urandom_range(3) != 0) v = $urandom_range(0, 100);
        REG_ADC_SCALE: if (!extreme && $urandom_range(3) != 0) v = $urandom_range(0, 40_000);
        REG_VBASE, REG_R1:
          if (!extreme && $urandom_range(3) != 0) v = $urandom_range(0, 2_000_000);
        default: ;
      endcase
      write_reg(3'(i), v);
    end
  endtask

  task automatic test_random_phase(int idle_send, int idle_recv, int n);
    send_idle_pct = idle_send;
    recv_idle_pct = idle_recv;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) begin
        drain();
        randomize_regs(k % 256 == 128);
      end
      send_sample(16'($urandom()));
    end
    drain();
  endtask

  initial begin
    reset_shadow();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    test_random_phase(18, 51, 384);
    test_random_phase(51, 18, 384);
    test_random_phase(0, 0, 384);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("positional_pid_digipot_drive_unit test passed");
    end else begin
      $display("positional_pid_digipot_drive_unit test failed");
    end
    $finish;
  end
endmodule
